// ----- sv/ptc_pkg.sv -----
// Shared types and constants for the pressure and temperature compensation pipeline.
// No dependencies; imported by every module of the block.
package ptc_pkg;

	localparam int FRONT_STAGES = 9;
	localparam int DIV_PRE_STAGES = 3;
	localparam int POST_STAGES = 4;
	localparam int QBITS = 37;
	localparam int DIV_W = 86;
	localparam int LATENCY = FRONT_STAGES + DIV_PRE_STAGES + QBITS + POST_STAGES;

	localparam logic [1:0] REG_CAL0 = 2'd0;
	localparam logic [1:0] REG_CAL1 = 2'd1;
	localparam logic [1:0] REG_CAL2 = 2'd2;

	localparam logic [QBITS-1:0] QUOT_LIMIT = 37'h10_0000_0000;
	localparam logic [24:0] PRESS_MAX = 25'h1FF_FFFF;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} ptc_cal_t;

	typedef struct packed {
		logic [15:0] temp;
		logic        neg;
		logic        nz;
	} ptc_side_t;

endpackage

// ----- sv/pressure_temperature_compensation_top.sv -----
// Throughput: one transaction per cycle; busy stays low and results cannot be held off.
// Depth is set by the 37-stage restoring divider, one quotient bit per stage.
// Reset clears the valid pipeline and the calibration registers; no clearing pass.
// Top level: ties the calibration port, front pipeline, divider and back pipeline.
module pressure_temperature_compensation_top import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  baro_msb,
	input  logic [7:0]  baro_lsb,
	input  logic [7:0]  baro_xlsb,
	input  logic [7:0]  temp_msb,
	input  logic [7:0]  temp_lsb,
	input  logic [7:0]  temp_xlsb,
	output logic        done,
	output logic [15:0] temperature_centi,
	output logic [24:0] pressure_pa_q8,
	output logic        result_valid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	ptc_cal_t           cal;
	logic               fr_valid, dv_valid;
	logic [64:0]        fr_un;
	logic signed [48:0] fr_den;
	ptc_side_t          fr_side, dv_side;
	logic [QBITS-1:0]   dv_q;
	logic               dv_ovf;

	assign busy = 1'b0;
	assign pready = 1'b1;

	ptc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cal     (cal)
	);

	ptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start & ~busy),
		.baro_msb   (baro_msb),
		.baro_lsb   (baro_lsb),
		.baro_xlsb  (baro_xlsb),
		.temp_msb   (temp_msb),
		.temp_lsb   (temp_lsb),
		.temp_xlsb  (temp_xlsb),
		.cal        (cal),
		.out_valid  (fr_valid),
		.un         (fr_un),
		.den        (fr_den),
		.side       (fr_side)
	);

	ptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.un        (fr_un),
		.den       (fr_den),
		.in_side   (fr_side),
		.out_valid (dv_valid),
		.q         (dv_q),
		.ovf       (dv_ovf),
		.out_side  (dv_side)
	);

	ptc_post u_post (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (dv_valid),
		.q                 (dv_q),
		.ovf               (dv_ovf),
		.in_side           (dv_side),
		.cal               (cal),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_pa_q8    (pressure_pa_q8),
		.result_valid      (result_valid)
	);

endmodule

// ----- sv/ptc_cfg.sv -----
// Calibration register file behind the APB-style write/read port.
// Depends on ptc_pkg for register codes and the calibration struct.
module ptc_cfg import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output ptc_cal_t    cal
);

	logic [63:0] cal0_q, cal1_q, cal2_q;
	logic        wr;
	logic [1:0]  idx;

	assign wr = psel & penable & pwrite;
	assign idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_CAL0: cal0_q <= pwdata;
				REG_CAL1: cal1_q <= pwdata;
				REG_CAL2: cal2_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CAL0: prdata = cal0_q;
			REG_CAL1: prdata = cal1_q;
			REG_CAL2: prdata = cal2_q;
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		cal.t1 = cal0_q[15:0];
		cal.t2 = cal0_q[31:16];
		cal.t3 = cal0_q[47:32];
		cal.p1 = cal0_q[63:48];
		cal.p2 = cal1_q[15:0];
		cal.p3 = cal1_q[31:16];
		cal.p4 = cal1_q[47:32];
		cal.p5 = cal1_q[63:48];
		cal.p6 = cal2_q[15:0];
		cal.p7 = cal2_q[31:16];
		cal.p8 = cal2_q[47:32];
		cal.p9 = cal2_q[63:48];
	end

endmodule

// ----- sv/ptc_front.sv -----
// Front pipeline: raw code assembly, temperature, t_fine and the pressure
// numerator and denominator. Depends on ptc_pkg.
module ptc_front import ptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         baro_msb,
	input  logic [7:0]         baro_lsb,
	input  logic [7:0]         baro_xlsb,
	input  logic [7:0]         temp_msb,
	input  logic [7:0]         temp_lsb,
	input  logic [7:0]         temp_xlsb,
	input  ptc_cal_t           cal,
	output logic               out_valid,
	output logic [64:0]        un,
	output logic signed [48:0] den,
	output ptc_side_t          side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [19:0] adct_s1;
	logic signed [34:0] vam_s2;
	logic signed [35:0] dd_s2;
	logic signed [23:0] va_s3;
	logic signed [39:0] vbm_s3;
	logic [15:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [27:0] v1_s4;
	logic signed [55:0] sq_s5;
	logic signed [43:0] v1p5_s5, v1p2_s5, v1p5_s6, v1p2_s6;
	logic signed [71:0] m6_s6, m3_s6;
	logic signed [63:0] v2_s7, a_s7;
	logic signed [63:0] mh_s8;
	logic [32:0] ml_s8;
	logic signed [65:0] num_s8;
	logic [64:0] un_s9;
	logic signed [48:0] den_s9;
	ptc_side_t side_s9;

	logic signed [18:0] tdiff;
	logic signed [34:0] vam;
	logic signed [17:0] dlt;
	logic signed [35:0] dsq;
	logic signed [23:0] dsh;
	logic signed [39:0] vbm;
	logic signed [25:0] vb;
	logic signed [26:0] tfine;
	logic signed [29:0] tf5;
	logic signed [21:0] temp_w;
	logic [15:0] temp_sat;
	logic signed [27:0] v1;
	logic signed [55:0] v1sq;
	logic signed [43:0] v1p5, v1p2;
	logic signed [71:0] m6, m3;
	logic signed [71:0] t5w, t4w, t2w, v2w, v1bw, aw;
	logic signed [46:0] ah;
	logic [16:0] al;
	logic signed [63:0] mh;
	logic [32:0] ml;
	logic [20:0] pw;
	logic signed [65:0] numw, negn;
	logic signed [64:0] sumd;

	always_comb begin
		tdiff = $signed({2'b00, adct_s1[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
		vam = tdiff * $signed(cal.t2);
		dlt = $signed({2'b00, adct_s1[19:4]}) - $signed({2'b00, cal.t1});
		dsq = dlt * dlt;

		dsh = $signed(dd_s2[35:12]);
		vbm = dsh * $signed(cal.t3);

		vb = $signed(vbm_s3[39:14]);
		tfine = va_s3 + vb;
		tf5 = tfine * 30'sd5 + 30'sd128;
		temp_w = $signed(tf5[29:8]);
		if (temp_w > 22'sd32767) begin
			temp_sat = 16'h7FFF;
		end else if (temp_w < -22'sd32768) begin
			temp_sat = 16'h8000;
		end else begin
			temp_sat = temp_w[15:0];
		end
		v1 = tfine - 28'sd128000;

		v1sq = v1_s4 * v1_s4;
		v1p5 = v1_s4 * $signed(cal.p5);
		v1p2 = v1_s4 * $signed(cal.p2);

		m6 = sq_s5 * $signed(cal.p6);
		m3 = sq_s5 * $signed(cal.p3);

		t5w = v1p5_s6;
		t4w = $signed(cal.p4);
		t2w = v1p2_s6;
		v2w = m6_s6 + (t5w <<< 17) + (t4w <<< 35);
		v1bw = $signed(m3_s6[63:8]) + (t2w <<< 12);
		aw = v1bw + (72'sd1 <<< 47);

		ah = $signed(a_s7[63:17]);
		al = a_s7[16:0];
		mh = ah * $signed({1'b0, cal.p1});
		ml = al * cal.p1;
		pw = 21'd1048576 - {1'b0, adcp_s7};
		numw = $signed({1'b0, pw, 31'b0}) - v2_s7;

		sumd = mh_s8 + $signed({1'b0, ml_s8[32:17]});
		negn = -num_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		adcp_s1 <= {baro_msb, baro_lsb, baro_xlsb[7:4]};
		adct_s1 <= {temp_msb, temp_lsb, temp_xlsb[7:4]};

		adcp_s2 <= adcp_s1;
		vam_s2 <= vam;
		dd_s2 <= dsq;

		adcp_s3 <= adcp_s2;
		va_s3 <= $signed(vam_s2[34:11]);
		vbm_s3 <= vbm;

		adcp_s4 <= adcp_s3;
		temp_s4 <= temp_sat;
		v1_s4 <= v1;

		adcp_s5 <= adcp_s4;
		temp_s5 <= temp_s4;
		sq_s5 <= v1sq;
		v1p5_s5 <= v1p5;
		v1p2_s5 <= v1p2;

		adcp_s6 <= adcp_s5;
		temp_s6 <= temp_s5;
		m6_s6 <= m6;
		m3_s6 <= m3;
		v1p5_s6 <= v1p5_s5;
		v1p2_s6 <= v1p2_s5;

		adcp_s7 <= adcp_s6;
		temp_s7 <= temp_s6;
		v2_s7 <= v2w[63:0];
		a_s7 <= aw[63:0];

		temp_s8 <= temp_s7;
		mh_s8 <= mh;
		ml_s8 <= ml;
		num_s8 <= {{2{numw[63]}}, numw[63:0]};

		den_s9 <= $signed(sumd[64:16]);
		un_s9 <= num_s8[65] ? negn[64:0] : num_s8[64:0];
		side_s9.temp <= temp_s8;
		side_s9.neg <= num_s8[65];
		side_s9.nz <= 1'b0;
	end

	assign out_valid = v_s9;
	assign un = un_s9;
	assign den = den_s9;
	assign side = side_s9;

endmodule

// ----- sv/ptc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, with saturation flag.
// Depends on ptc_pkg for widths and the side-band struct.
module ptc_div import ptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [64:0]        un,
	input  logic signed [48:0] den,
	input  ptc_side_t          in_side,
	output logic               out_valid,
	output logic [QBITS-1:0]   q,
	output logic               ovf,
	output ptc_side_t          out_side
);

	logic v_s1, v_s2;
	logic [48:0] ud_s1, ud_s2;
	logic [69:0] m25_s1;
	logic [76:0] n_s2;
	ptc_side_t side_s1, side_s2;

	logic [48:0] nden;
	logic [69:0] m25;
	logic [76:0] nw;

	logic [QBITS:0]       vld_si;
	logic [DIV_W-1:0]     rem_si  [QBITS+1];
	logic [QBITS-1:0]     quo_si  [QBITS+1];
	logic [48:0]          ud_si   [QBITS+1];
	logic                 ovf_si  [QBITS+1];
	ptc_side_t            side_si [QBITS+1];

	always_comb begin
		nden = -den;
		m25 = (70'(un) << 4) + (70'(un) << 3) + 70'(un);
		nw = (77'(m25_s1) << 7) - (77'(m25_s1) << 1) - 77'(m25_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vld_si <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			vld_si <= {vld_si[QBITS-1:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		ud_s1 <= den[48] ? nden : den;
		m25_s1 <= m25;
		side_s1.temp <= in_side.temp;
		side_s1.neg <= in_side.neg ^ den[48];
		side_s1.nz <= |den;

		ud_s2 <= ud_s1;
		n_s2 <= nw;
		side_s2 <= side_s1;

		rem_si[0] <= DIV_W'(n_s2);
		quo_si[0] <= '0;
		ud_si[0] <= ud_s2;
		ovf_si[0] <= DIV_W'(n_s2) >= (DIV_W'(ud_s2) << QBITS);
		side_si[0] <= side_s2;
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_iter
		localparam int SH = QBITS - 1 - k;
		logic [DIV_W-1:0] trial;
		logic             take;

		assign trial = DIV_W'(ud_si[k]) << SH;
		assign take = rem_si[k] >= trial;

		always_ff @(posedge clk) begin
			rem_si[k+1] <= take ? rem_si[k] - trial : rem_si[k];
			quo_si[k+1] <= quo_si[k] | (take ? (QBITS'(1) << SH) : '0);
			ud_si[k+1] <= ud_si[k];
			ovf_si[k+1] <= ovf_si[k];
			side_si[k+1] <= side_si[k];
		end
	end

	assign out_valid = vld_si[QBITS];
	assign q = quo_si[QBITS];
	assign ovf = ovf_si[QBITS];
	assign out_side = side_si[QBITS];

endmodule

// ----- sv/ptc_post.sv -----
// Back pipeline: signed quotient, second-order pressure correction and output clamp.
// Depends on ptc_pkg for the calibration and side-band structs.
module ptc_post import ptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [QBITS-1:0] q,
	input  logic             ovf,
	input  ptc_side_t        in_side,
	input  ptc_cal_t         cal,
	output logic             done,
	output logic [15:0]      temperature_centi,
	output logic [24:0]      pressure_pa_q8,
	output logic             result_valid
);

	logic v_s1, v_s2, v_s3, done_q;
	logic signed [37:0] p_s1, p_s2, p_s3;
	logic signed [49:0] pp_s2;
	logic signed [53:0] c2m_s2, c2m_s3;
	logic signed [65:0] c1m_s3;
	ptc_side_t side_s1, side_s2, side_s3;
	logic [15:0] temp_q;
	logic [24:0] press_q;
	logic        valid_q;

	logic [QBITS-1:0]   qs;
	logic signed [37:0] qw;
	logic signed [24:0] ps;
	logic signed [49:0] pp;
	logic signed [53:0] c2m;
	logic signed [65:0] c1m;
	logic signed [42:0] sum;
	logic signed [43:0] p7w, rw;
	logic [24:0]        clamp;

	always_comb begin
		qs = (ovf || q > QUOT_LIMIT) ? QUOT_LIMIT : q;
		qw = $signed({1'b0, qs});

		ps = $signed(p_s1[37:13]);
		pp = ps * ps;
		c2m = p_s1 * $signed(cal.p8);

		c1m = pp_s2 * $signed(cal.p9);

		sum = p_s3 + $signed(c1m_s3[65:25]) + $signed(c2m_s3[53:19]);
		p7w = $signed(cal.p7);
		rw = $signed(sum[42:8]) + (p7w <<< 4);
		if (rw < 44'sd0) begin
			clamp = '0;
		end else if (rw > $signed({19'b0, PRESS_MAX})) begin
			clamp = PRESS_MAX;
		end else begin
			clamp = rw[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_side.neg ? -qw : qw;
		side_s1 <= in_side;

		p_s2 <= p_s1;
		pp_s2 <= pp;
		c2m_s2 <= c2m;
		side_s2 <= side_s1;

		p_s3 <= p_s2;
		c1m_s3 <= c1m;
		c2m_s3 <= c2m_s2;
		side_s3 <= side_s2;

		temp_q <= side_s3.temp;
		press_q <= side_s3.nz ? clamp : '0;
		valid_q <= side_s3.nz;
	end

	assign done = done_q;
	assign temperature_centi = temp_q;
	assign pressure_pa_q8 = press_q;
	assign result_valid = valid_q;

endmodule

// ----- sv/ptc_checker.sv -----
// Port-level checks on the compensation top level, attached by bind.
// Depends on ptc_pkg for the pipeline latency.
module ptc_checker import ptc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [24:0] pressure_pa_q8,
	input logic        result_valid
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without a transaction accepted at the pipeline latency");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result_valid) |-> (pressure_pa_q8 == 25'd0))
		else $error("pressure nonzero on an invalid result");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("done right after reset");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.pressure_pa_q8 (pressure_pa_q8),
	.result_valid   (result_valid)
);

// ----- sim/tb.sv -----
// Self-checking testbench for pressure_temperature_compensation_top.
// Drives raw sensor transactions and calibration words over APB and checks each
// result against a built-in fixed-point predictor; depends on ptc_pkg and the RTL.
module tb import ptc_pkg::*;;

	typedef longint unsigned u64;

	typedef struct {
		logic [7:0] pm, pl, px, tm, tl, tx;
	} raw_t;

	typedef struct {
		logic [15:0] temp;
		logic [24:0] press;
		logic        valid;
	} comp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  baro_msb = '0, baro_lsb = '0, baro_xlsb = '0;
	logic [7:0]  temp_msb = '0, temp_lsb = '0, temp_xlsb = '0;
	logic        done;
	logic [15:0] temperature_centi;
	logic [24:0] pressure_pa_q8;
	logic        result_valid;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	pressure_temperature_compensation_top i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0] cal [3];
	raw_t  raw_queue [$];
	comp_t comp_queue [$];
	int    errors = 0;
	int    n_in = 0, n_out = 0, n_invalid = 0;
	bit    took = 1'b0;
	int    burst = 0, gap = 0, idle_cycles = 0;

	function automatic comp_t compensate(input raw_t r);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint adc_p, adc_t, va, d, vb, tf, tmp, v1, v2, a, ah, al, den, num;
		longint p, ps, c1, c2;
		u64 un, ud, qa, ra, q, alp, lim;
		bit neg;
		comp_t c;
		t1 = longint'(cal[0][15:0]);
		t2 = longint'($signed(cal[0][31:16]));
		t3 = longint'($signed(cal[0][47:32]));
		p1 = longint'(cal[0][63:48]);
		p2 = longint'($signed(cal[1][15:0]));
		p3 = longint'($signed(cal[1][31:16]));
		p4 = longint'($signed(cal[1][47:32]));
		p5 = longint'($signed(cal[1][63:48]));
		p6 = longint'($signed(cal[2][15:0]));
		p7 = longint'($signed(cal[2][31:16]));
		p8 = longint'($signed(cal[2][47:32]));
		p9 = longint'($signed(cal[2][63:48]));
		adc_p = longint'({r.pm, r.pl, r.px[7:4]});
		adc_t = longint'({r.tm, r.tl, r.tx[7:4]});
		va = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		vb = (((d * d) >>> 12) * t3) >>> 14;
		tf = va + vb;
		tmp = (tf * 5 + 128) >>> 8;
		if (tmp > 32767) tmp = 32767;
		if (tmp < -32768) tmp = -32768;
		v1 = tf - 128000;
		v2 = v1 * v1 * p6;
		v2 += v1 * p5 * 131072;
		v2 += p4 * (longint'(1) <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
		a = (longint'(1) <<< 47) + v1;
		ah = a >>> 17;
		al = a - ah * 131072;
		alp = (u64'(al) * u64'(p1)) >> 17;
		den = (ah * p1 + longint'(alp)) >>> 16;
		c.temp = tmp[15:0];
		c.press = '0;
		c.valid = 1'b0;
		if (den != 0) begin
			lim = u64'(1) << 36;
			num = (1048576 - adc_p) * (longint'(1) <<< 31) - v2;
			neg = (num < 0) != (den < 0);
			un = num < 0 ? u64'(-num) : u64'(num);
			ud = den < 0 ? u64'(-den) : u64'(den);
			qa = un / ud;
			ra = un % ud;
			if (qa > lim)
				q = lim;
			else
				q = qa * 3125 + (ra * 3125) / ud;
			if (q > lim) q = lim;
			p = neg ? -longint'(q) : longint'(q);
			ps = p >>> 13;
			c1 = (p9 * ps * ps) >>> 25;
			c2 = (p8 * p) >>> 19;
			p = ((p + c1 + c2) >>> 8) + p7 * 16;
			if (p < 0) p = 0;
			if (p > 33554431) p = 33554431;
			c.press = p[24:0];
			c.valid = 1'b1;
		end
		return c;
	endfunction

	// driver: bursts with random gaps, inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (raw_queue.size() > 0) begin
				baro_msb <= raw_queue[0].pm;
				baro_lsb <= raw_queue[0].pl;
				baro_xlsb <= raw_queue[0].px;
				temp_msb <= raw_queue[0].tm;
				temp_lsb <= raw_queue[0].tl;
				temp_xlsb <= raw_queue[0].tx;
				void'(raw_queue.pop_front());
				start <= 1'b1;
				if (burst <= 1) begin
					burst <= $urandom_range(1, 24);
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst <= burst - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: sample on the rising edge, predict on acceptance, check on done
	always @(posedge clk) begin
		raw_t  r;
		comp_t e;
		took <= arst_n && start && !busy;
		if (arst_n) begin
			if (start && !busy) begin
				r.pm = baro_msb; r.pl = baro_lsb; r.px = baro_xlsb;
				r.tm = temp_msb; r.tl = temp_lsb; r.tx = temp_xlsb;
				comp_queue.push_back(compensate(r));
				n_in++;
			end
			if (done) begin
				n_out++;
				if (!result_valid) n_invalid++;
				if (comp_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: temp=%0d press=%0d valid=%0b",
							$signed(temperature_centi), pressure_pa_q8, result_valid);
				end else begin
					e = comp_queue.pop_front();
					if (e.temp !== temperature_centi || e.press !== pressure_pa_q8 ||
							e.valid !== result_valid) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp temp=%0d press=%0d valid=%0b,",
								$signed(e.temp), e.press, e.valid,
								" got temp=%0d press=%0d valid=%0b",
								$signed(temperature_centi), pressure_pa_q8,
								result_valid);
					end
				end
			end
			if ((start && !busy) || done || (raw_queue.size() == 0 && comp_queue.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 2000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic cal_write(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cal[idx] = val;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic load_cal(input logic [63:0] c0, c1, c2);
		cal_write(REG_CAL0, c0);
		cal_write(REG_CAL1, c1);
		cal_write(REG_CAL2, c2);
	endtask

	task automatic push_raw(input logic [7:0] pm, pl, px, tm, tl, tx);
		raw_t r;
		r.pm = pm; r.pl = pl; r.px = px; r.tm = tm; r.tl = tl; r.tx = tx;
		raw_queue.push_back(r);
	endtask

	// realistic raw codes near room conditions, or fully random bytes
	task automatic push_random(input int n);
		logic [19:0] ap, at;
		repeat (n) begin
			if ($urandom_range(0, 2) != 0) begin
				ap = 20'(415148 + $urandom_range(0, 120000) - 60000);
				at = 20'(519888 + $urandom_range(0, 120000) - 60000);
				push_raw(ap[19:12], ap[11:4], {ap[3:0], 4'($urandom)},
					at[19:12], at[11:4], {at[3:0], 4'($urandom)});
			end else begin
				push_raw(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic drain();
		while (!(raw_queue.size() == 0 && !start && comp_queue.size() == 0))
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		cal[0] = '0; cal[1] = '0; cal[2] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset calibration: zero denominator
		push_raw(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00);
		push_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		drain();

		load_cal({16'd36477, 16'hFC18, 16'd26435, 16'd27504},
			{16'd140, 16'd2855, 16'd3024, 16'hD643},
			{16'd6000, 16'hC6F8, 16'd15500, 16'hFFF9});
		push_raw(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00);
		push_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_raw(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h0F);
		push_raw(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 8'hF0);
		push_raw(8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00);
		push_raw(8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hFF, 8'hF0);
		push_raw(8'h55, 8'hAA, 8'h50, 8'hAA, 8'h55, 8'hA0);
		push_raw(8'hAA, 8'h55, 8'hA0, 8'h55, 8'hAA, 8'h50);
		push_random(130);
		drain();

		load_cal('1, '1, '1);
		push_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_random(30);
		drain();

		load_cal(64'h0000_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
		push_raw(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0);
		push_random(30);
		drain();

		load_cal(64'hFFFF_8000_8000_0000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
		push_raw(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00);
		push_random(30);
		drain();

		repeat (4) begin
			load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			push_random(40);
			drain();
		end

		// zero P1 again forces an invalid result
		load_cal(64'h0000_FC18_6743_6B70, cal[1], cal[2]);
		push_random(10);
		drain();

		if (comp_queue.size() != 0) errors += comp_queue.size();
		$display("covered %0d transactions and %0d results (%0d with zero denominator)",
			n_in, n_out, n_invalid);
		$display("calibration sets: reset, typical, all ones, extremes and random");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/ptc_pkg.sv
sv/ptc_cfg.sv
sv/ptc_front.sv
sv/ptc_div.sv
sv/ptc_post.sv
sv/pressure_temperature_compensation_top.sv
sv/ptc_checker.sv
sim/tb.sv
